/* rtl/lav_pkg.sv */
// lav_pkg: shared types, constants and rounding helpers for the look-at view matrix block
// request and response payload structs, row codes and fixed-point helpers
// no dependencies
`default_nettype none

package lav_pkg;

   localparam int D_IN_W   = 33;
   localparam int D_SIDE_W = 192;
   localparam int R_IN_W   = 64;
   localparam int R_SIDE_W = 193;

   localparam logic signed [63:0] Q30_ONE   = 64'sd1073741824;
   localparam logic signed [63:0] Q30_HALF  = 64'sd536870912;
   localparam logic signed [63:0] S32_MAX   = 64'sd2147483647;
   localparam logic signed [63:0] S32_MIN   = -64'sd2147483648;

   localparam logic [1:0] ROW_RIGHT = 2'd0;
   localparam logic [1:0] ROW_UP    = 2'd1;
   localparam logic [1:0] ROW_BACK  = 2'd2;

   typedef struct packed {
      logic signed [31:0] eye_x;
      logic signed [31:0] eye_y;
      logic signed [31:0] eye_z;
      logic signed [31:0] target_x;
      logic signed [31:0] target_y;
      logic signed [31:0] target_z;
      logic signed [31:0] up_x;
      logic signed [31:0] up_y;
      logic signed [31:0] up_z;
   } lav_req_type;

   typedef struct packed {
      logic [1:0]         row_index;
      logic               last_row;
      logic signed [31:0] coef_x;
      logic signed [31:0] coef_y;
      logic signed [31:0] coef_z;
      logic signed [31:0] offset;
      logic               degenerate;
   } lav_rsp_type;

   typedef struct packed {
      logic [2:0][31:0] coef;
      logic [31:0]      offs;
   } lav_row_type;

   typedef struct packed {
      lav_row_type [2:0] row;
      logic              degenerate;
   } lav_item_type;

   // round(x / 2^30), half away from zero
   function automatic logic signed [63:0] round_q30(input logic signed [63:0] x);
      logic [63:0] mag;
      logic [63:0] r;
      mag = x[63] ? (64'd0 - x) : x;
      r   = (mag + Q30_HALF) >> 30;
      return x[63] ? $signed(64'd0 - r) : $signed(r);
   endfunction

   function automatic logic [31:0] clamp_unit(input logic signed [63:0] x);
      logic [31:0] res;
      if (x > Q30_ONE) begin
         res = Q30_ONE[31:0];
      end else if (x < -Q30_ONE) begin
         res = 32'hC000_0000;
      end else begin
         res = x[31:0];
      end
      return res;
   endfunction

   function automatic logic [31:0] sat32(input logic signed [63:0] x);
      logic [31:0] res;
      if (x > S32_MAX) begin
         res = 32'h7FFF_FFFF;
      end else if (x < S32_MIN) begin
         res = 32'h8000_0000;
      end else begin
         res = x[31:0];
      end
      return res;
   endfunction

endpackage

`default_nettype wire

/* rtl/look_at_view_matrix.sv */
// look_at_view_matrix: right-handed look-at view matrix rows in fixed point
// request stage, two normalizer pipelines, cross and dot stages, row buffer
// depends on lav_pkg and lav_norm
//
// usage:
//   req_valid/req_ready/req_data carry one request: eye, target and world
//   up, signed 32-bit coordinates. each request yields three responses on
//   rsp_valid/rsp_ready/rsp_data, rows right, camera up, backward, with
//   last_row set on the third. degenerate is set with zero fields when the
//   eye equals the target or up is parallel to the view direction.
// order: the first row is offered once the request has passed both normalizers, the cross and
//   dot stages and the row buffer; the next rows follow one per cycle while rsp_ready is high.
// throughput: the pipeline takes a request every cycle while the row buffer is not full; the
//   response side returns three rows per request.
// reset: synchronous, active high; clears all valid bits and the row buffer's pointers, count and row.
// stall: the pipeline feeds a two-request row buffer; when it is full the
//   whole pipeline holds and req_ready drops, nothing is lost or repeated.
`default_nettype none

module look_at_view_matrix (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  lav_pkg::lav_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output lav_pkg::lav_rsp_type rsp_data
);
   import lav_pkg::*;

   logic en;

   // request stage
   logic             s0_vld_ff;
   logic [2:0][31:0] s0_eye_ff;
   logic [2:0][31:0] s0_up_ff;
   logic [2:0][32:0] s0_dv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
      end else if (en) begin
         s0_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_eye_ff   <= {req_data.eye_z, req_data.eye_y, req_data.eye_x};
         s0_up_ff    <= {req_data.up_z, req_data.up_y, req_data.up_x};
         s0_dv_ff[0] <= 33'(req_data.eye_x) - 33'(req_data.target_x);
         s0_dv_ff[1] <= 33'(req_data.eye_y) - 33'(req_data.target_y);
         s0_dv_ff[2] <= 33'(req_data.eye_z) - 33'(req_data.target_z);
      end
   end

   // backward direction
   logic                n1_vld;
   logic                n1_ok;
   logic [2:0][31:0]    n1_vec;
   logic [D_SIDE_W-1:0] n1_side;
   logic [2:0][31:0]    n1_eye;
   logic [2:0][31:0]    n1_up;

   lav_norm #(
      .IN_W   (D_IN_W),
      .SIDE_W (D_SIDE_W)
   ) u_norm_d (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s0_vld_ff),
      .in_vec    (s0_dv_ff),
      .in_side   ({s0_eye_ff, s0_up_ff}),
      .out_valid (n1_vld),
      .out_ok    (n1_ok),
      .out_vec   (n1_vec),
      .out_side  (n1_side)
   );

   assign n1_eye = n1_side[191:96];
   assign n1_up  = n1_side[95:0];

   // up x d products
   logic                     s1_vld_ff;
   logic                     s1_ok_ff;
   logic [2:0][31:0]         s1_eye_ff;
   logic [2:0][31:0]         s1_d_ff;
   logic signed [5:0][63:0]  s1_p_ff;

   // right vector, unnormalized
   logic                     s2_vld_ff;
   logic                     s2_ok_ff;
   logic [2:0][31:0]         s2_eye_ff;
   logic [2:0][31:0]         s2_d_ff;
   logic [2:0][63:0]         s2_rv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else if (en) begin
         s1_vld_ff <= n1_vld;
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ok_ff   <= n1_ok;
         s1_eye_ff  <= n1_eye;
         s1_d_ff    <= n1_vec;
         s1_p_ff[0] <= $signed(n1_up[1]) * $signed(n1_vec[2]);
         s1_p_ff[1] <= $signed(n1_up[2]) * $signed(n1_vec[1]);
         s1_p_ff[2] <= $signed(n1_up[2]) * $signed(n1_vec[0]);
         s1_p_ff[3] <= $signed(n1_up[0]) * $signed(n1_vec[2]);
         s1_p_ff[4] <= $signed(n1_up[0]) * $signed(n1_vec[1]);
         s1_p_ff[5] <= $signed(n1_up[1]) * $signed(n1_vec[0]);
         s2_ok_ff    <= s1_ok_ff;
         s2_eye_ff   <= s1_eye_ff;
         s2_d_ff     <= s1_d_ff;
         s2_rv_ff[0] <= s1_p_ff[0] - s1_p_ff[1];
         s2_rv_ff[1] <= s1_p_ff[2] - s1_p_ff[3];
         s2_rv_ff[2] <= s1_p_ff[4] - s1_p_ff[5];
      end
   end

   // right vector
   logic                n2_vld;
   logic                n2_ok;
   logic [2:0][31:0]    n2_vec;
   logic [R_SIDE_W-1:0] n2_side;
   logic [2:0][31:0]    n2_eye;
   logic [2:0][31:0]    n2_d;
   logic                n2_okd;

   lav_norm #(
      .IN_W   (R_IN_W),
      .SIDE_W (R_SIDE_W)
   ) u_norm_r (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s2_vld_ff),
      .in_vec    (s2_rv_ff),
      .in_side   ({s2_eye_ff, s2_d_ff, s2_ok_ff}),
      .out_valid (n2_vld),
      .out_ok    (n2_ok),
      .out_vec   (n2_vec),
      .out_side  (n2_side)
   );

   assign n2_eye = n2_side[192:97];
   assign n2_d   = n2_side[96:1];
   assign n2_okd = n2_side[0];

   // d x r products
   logic                     s3_vld_ff;
   logic                     s3_ok_ff;
   logic [2:0][31:0]         s3_eye_ff;
   logic [2:0][31:0]         s3_d_ff;
   logic [2:0][31:0]         s3_r_ff;
   logic signed [5:0][63:0]  s3_p_ff;

   // camera up
   logic                     s4_vld_ff;
   logic                     s4_ok_ff;
   logic [2:0][31:0]         s4_eye_ff;
   logic [2:0][31:0]         s4_d_ff;
   logic [2:0][31:0]         s4_r_ff;
   logic [2:0][31:0]         s4_u_ff;

   // row times eye products
   logic                          s5_vld_ff;
   logic                          s5_ok_ff;
   logic [2:0][2:0][31:0]         s5_rows_ff;
   logic signed [2:0][2:0][63:0]  s5_p_ff;

   // dot sums
   logic                     s6_vld_ff;
   logic                     s6_ok_ff;
   logic [2:0][2:0][31:0]    s6_rows_ff;
   logic signed [2:0][63:0]  s6_sum_ff;

   // finished item
   logic                     s7_vld_ff;
   lav_item_type             s7_item_ff;
   lav_item_type             s7_item_in;
   logic [2:0][2:0][31:0]    s5_rows_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
         s5_vld_ff <= 1'b0;
         s6_vld_ff <= 1'b0;
         s7_vld_ff <= 1'b0;
      end else if (en) begin
         s3_vld_ff <= n2_vld;
         s4_vld_ff <= s3_vld_ff;
         s5_vld_ff <= s4_vld_ff;
         s6_vld_ff <= s5_vld_ff;
         s7_vld_ff <= s6_vld_ff;
      end
   end

   assign s5_rows_in = {s4_d_ff, s4_u_ff, s4_r_ff};

   always_comb begin
      logic signed [63:0] off;
      s7_item_in.degenerate = !s6_ok_ff;
      for (int k = 0; k < 3; k++) begin
         off = 64'sd0 - round_q30(s6_sum_ff[k]);
         if (s6_ok_ff) begin
            s7_item_in.row[k].coef = s6_rows_ff[k];
            s7_item_in.row[k].offs = sat32(off);
         end else begin
            s7_item_in.row[k].coef = '0;
            s7_item_in.row[k].offs = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_ok_ff   <= n2_okd & n2_ok;
         s3_eye_ff  <= n2_eye;
         s3_d_ff    <= n2_d;
         s3_r_ff    <= n2_vec;
         s3_p_ff[0] <= $signed(n2_d[1]) * $signed(n2_vec[2]);
         s3_p_ff[1] <= $signed(n2_d[2]) * $signed(n2_vec[1]);
         s3_p_ff[2] <= $signed(n2_d[2]) * $signed(n2_vec[0]);
         s3_p_ff[3] <= $signed(n2_d[0]) * $signed(n2_vec[2]);
         s3_p_ff[4] <= $signed(n2_d[0]) * $signed(n2_vec[1]);
         s3_p_ff[5] <= $signed(n2_d[1]) * $signed(n2_vec[0]);

         s4_ok_ff   <= s3_ok_ff;
         s4_eye_ff  <= s3_eye_ff;
         s4_d_ff    <= s3_d_ff;
         s4_r_ff    <= s3_r_ff;
         s4_u_ff[0] <= clamp_unit(round_q30(s3_p_ff[0] - s3_p_ff[1]));
         s4_u_ff[1] <= clamp_unit(round_q30(s3_p_ff[2] - s3_p_ff[3]));
         s4_u_ff[2] <= clamp_unit(round_q30(s3_p_ff[4] - s3_p_ff[5]));

         s5_ok_ff   <= s4_ok_ff;
         s5_rows_ff <= s5_rows_in;
         for (int k = 0; k < 3; k++) begin
            for (int c = 0; c < 3; c++) begin
               s5_p_ff[k][c] <= $signed(s5_rows_in[k][c]) * $signed(s4_eye_ff[c]);
            end
         end

         s6_ok_ff   <= s5_ok_ff;
         s6_rows_ff <= s5_rows_ff;
         for (int k = 0; k < 3; k++) begin
            s6_sum_ff[k] <= s5_p_ff[k][0] + s5_p_ff[k][1] + s5_p_ff[k][2];
         end

         s7_item_ff <= s7_item_in;
      end
   end

   // two-request row buffer
   lav_item_type buf_ff [2];
   lav_item_type cur;
   logic         wr_ptr_ff;
   logic         rd_ptr_ff;
   logic [1:0]   cnt_ff;
   logic [1:0]   row_ff;
   logic         push;
   logic         pop;
   logic         take;

   assign en        = (cnt_ff != 2'd2);
   assign req_ready = en;
   assign rsp_valid = (cnt_ff != 2'd0);
   assign take      = rsp_valid && rsp_ready;
   assign push      = s7_vld_ff && en;
   assign pop       = take && (row_ff == ROW_BACK);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
         row_ff    <= ROW_RIGHT;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         if (take) begin
            row_ff <= (row_ff == ROW_BACK) ? ROW_RIGHT : (row_ff + 2'd1);
         end
         case ({push, pop})
            2'b10:   cnt_ff <= cnt_ff + 2'd1;
            2'b01:   cnt_ff <= cnt_ff - 2'd1;
            default: cnt_ff <= cnt_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         buf_ff[wr_ptr_ff] <= s7_item_ff;
      end
   end

   always_comb begin
      cur = buf_ff[rd_ptr_ff];
      rsp_data.row_index  = row_ff;
      rsp_data.last_row   = (row_ff == ROW_BACK);
      rsp_data.degenerate = cur.degenerate;
      case (row_ff)
         ROW_RIGHT: begin
            rsp_data.coef_x = cur.row[0].coef[0];
            rsp_data.coef_y = cur.row[0].coef[1];
            rsp_data.coef_z = cur.row[0].coef[2];
            rsp_data.offset = cur.row[0].offs;
         end
         ROW_UP: begin
            rsp_data.coef_x = cur.row[1].coef[0];
            rsp_data.coef_y = cur.row[1].coef[1];
            rsp_data.coef_z = cur.row[1].coef[2];
            rsp_data.offset = cur.row[1].offs;
         end
         ROW_BACK: begin
            rsp_data.coef_x = cur.row[2].coef[0];
            rsp_data.coef_y = cur.row[2].coef[1];
            rsp_data.coef_z = cur.row[2].coef[2];
            rsp_data.offset = cur.row[2].offs;
         end
         default: begin
            rsp_data.coef_x = '0;
            rsp_data.coef_y = '0;
            rsp_data.coef_z = '0;
            rsp_data.offset = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

/* rtl/lav_norm.sv */
// lav_norm: pipelined vector normalizer to signed Q1.30
// range shift, squares, one root bit and one quotient bit per stage
// depends on lav_pkg
`default_nettype none

module lav_norm #(
   parameter int IN_W   = lav_pkg::D_IN_W,
   parameter int SIDE_W = lav_pkg::D_SIDE_W
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  logic [2:0][IN_W-1:0]  in_vec,
   input  logic [SIDE_W-1:0]     in_side,
   output logic                  out_valid,
   output logic                  out_ok,
   output logic [2:0][31:0]      out_vec,
   output logic [SIDE_W-1:0]     out_side
);
   import lav_pkg::*;

   localparam int NSH    = 6;
   localparam int SQ_N   = 32;
   localparam int DIV_N  = 31;
   localparam int LAT    = NSH + SQ_N + DIV_N + 5;
   localparam int META_W = SIDE_W + 4;

   logic              vld_ff  [LAT];
   logic [META_W-1:0] meta_ff [LAT];
   logic [META_W-1:0] meta_in;

   logic [2:0][63:0]  mag_ff [NSH+1];
   logic [63:0]       top_ff [NSH+1];
   logic [2:0][63:0]  mag_in;
   logic [63:0]       top_in;

   logic [2:0][30:0]  msq_ff;
   logic [2:0][61:0]  sq_ff;

   logic [63:0]       s_ff    [SQ_N+1];
   logic [34:0]       rem_ff  [SQ_N+1];
   logic [31:0]       root_ff [SQ_N+1];
   logic [2:0][30:0]  msr_ff  [SQ_N+1];

   logic [31:0]       len_ff [DIV_N+1];
   logic [2:0][31:0]  r_ff   [DIV_N+1];
   logic [2:0][30:0]  nl_ff  [DIV_N+1];
   logic [2:0][30:0]  q_ff   [DIV_N+1];
   logic [2:0][61:0]  n_in;

   logic [2:0][31:0]  vec_ff;
   logic [2:0][31:0]  vec_in;

   // magnitudes and largest component
   always_comb begin
      logic [2:0]  sgn;
      logic [63:0] v;
      top_in = '0;
      for (int c = 0; c < 3; c++) begin
         sgn[c]    = in_vec[c][IN_W-1];
         v         = 64'($signed(in_vec[c]));
         mag_in[c] = sgn[c] ? (64'd0 - v) : v;
         if (mag_in[c] > top_in) top_in = mag_in[c];
      end
      meta_in = {(top_in != 64'd0), sgn, in_side};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LAT; i++) vld_ff[i] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_valid;
         for (int i = 1; i < LAT; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         meta_ff[0] <= meta_in;
         for (int i = 1; i < LAT; i++) meta_ff[i] <= meta_ff[i-1];
         mag_ff[0] <= mag_in;
         top_ff[0] <= top_in;
      end
   end

   // bring the largest magnitude into [2^30, 2^31)
   for (genvar j = 0; j < NSH; j++) begin : g_shift
      localparam int K  = 32 >> j;
      localparam int LK = (K < 31) ? (31 - K) : 0;
      logic [2:0][63:0] m_in;
      logic [63:0]      t_in;
      always_comb begin
         m_in = mag_ff[j];
         t_in = top_ff[j];
         if (top_ff[j] >= (64'd1 << (30 + K))) begin
            t_in = top_ff[j] >> K;
            for (int c = 0; c < 3; c++) m_in[c] = mag_ff[j][c] >> K;
         end else if ((K < 31) && (top_ff[j] < (64'd1 << LK))) begin
            t_in = top_ff[j] << K;
            for (int c = 0; c < 3; c++) m_in[c] = mag_ff[j][c] << K;
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            mag_ff[j+1] <= m_in;
            top_ff[j+1] <= t_in;
         end
      end
   end

   // squares
   always_ff @(posedge clock) begin
      if (en) begin
         for (int c = 0; c < 3; c++) begin
            msq_ff[c] <= mag_ff[NSH][c][30:0];
            sq_ff[c]  <= mag_ff[NSH][c][30:0] * mag_ff[NSH][c][30:0];
         end
      end
   end

   // sum of squares, root seed
   always_ff @(posedge clock) begin
      if (en) begin
         s_ff[0]    <= 64'(sq_ff[0]) + 64'(sq_ff[1]) + 64'(sq_ff[2]);
         rem_ff[0]  <= '0;
         root_ff[0] <= '0;
         msr_ff[0]  <= msq_ff;
      end
   end

   // integer square root, one bit per stage
   for (genvar i = 1; i <= SQ_N; i++) begin : g_sqrt
      logic [34:0] pre;
      logic [34:0] trial;
      logic [34:0] rem_in;
      logic [31:0] root_in;
      always_comb begin
         pre   = {rem_ff[i-1][32:0], s_ff[i-1][63:62]};
         trial = {1'b0, root_ff[i-1], 2'b01};
         if (pre >= trial) begin
            rem_in  = pre - trial;
            root_in = {root_ff[i-1][30:0], 1'b1};
         end else begin
            rem_in  = pre;
            root_in = {root_ff[i-1][30:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            s_ff[i]    <= {s_ff[i-1][61:0], 2'b00};
            rem_ff[i]  <= rem_in;
            root_ff[i] <= root_in;
            msr_ff[i]  <= msr_ff[i-1];
         end
      end
   end

   // rounded dividends
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         n_in[c] = {1'b0, msr_ff[SQ_N][c], 30'd0} + {31'd0, root_ff[SQ_N][31:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         len_ff[0] <= root_ff[SQ_N];
         for (int c = 0; c < 3; c++) begin
            r_ff[0][c]  <= {1'b0, n_in[c][61:31]};
            nl_ff[0][c] <= n_in[c][30:0];
            q_ff[0][c]  <= '0;
         end
      end
   end

   // restoring division, one quotient bit per stage
   for (genvar i = 1; i <= DIV_N; i++) begin : g_div
      logic [2:0][31:0] r_in;
      logic [2:0][30:0] q_in;
      logic [2:0][30:0] nl_in;
      always_comb begin
         logic [32:0] pre;
         logic        ge;
         for (int c = 0; c < 3; c++) begin
            pre      = {r_ff[i-1][c], nl_ff[i-1][c][30]};
            ge       = (pre >= {1'b0, len_ff[i-1]});
            r_in[c]  = ge ? 32'(pre - {1'b0, len_ff[i-1]}) : pre[31:0];
            q_in[c]  = {q_ff[i-1][c][29:0], ge};
            nl_in[c] = {nl_ff[i-1][c][29:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            len_ff[i] <= len_ff[i-1];
            r_ff[i]   <= r_in;
            q_ff[i]   <= q_in;
            nl_ff[i]  <= nl_in;
         end
      end
   end

   // clamp and sign
   always_comb begin
      logic [30:0] qc;
      for (int c = 0; c < 3; c++) begin
         qc = (q_ff[DIV_N][c] > 31'd1073741824) ? 31'd1073741824 : q_ff[DIV_N][c];
         vec_in[c] = meta_ff[LAT-2][SIDE_W+c] ? (32'd0 - {1'b0, qc}) : {1'b0, qc};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         vec_ff <= vec_in;
      end
   end

   assign out_valid = vld_ff[LAT-1];
   assign out_ok    = meta_ff[LAT-1][SIDE_W+3];
   assign out_side  = meta_ff[LAT-1][SIDE_W-1:0];
   assign out_vec   = vec_ff;

endmodule

`default_nettype wire

/* dv/tb_look_at_view_matrix.sv */
// tb_look_at_view_matrix: self-checking testbench for the look-at view matrix block
// predicts the three rows per request in 64-bit fixed point and checks every response
// depends on lav_pkg and look_at_view_matrix
`default_nettype none

module tb_look_at_view_matrix;
   import lav_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   lav_req_type req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   lav_rsp_type rsp_data;

   lav_rsp_type rows_due[$];
   int          n_fail;
   int          n_req;
   int          n_rows;
   int          n_degen;
   bit          hold_rsp;
   bit          sim_done;

   look_at_view_matrix dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #60000000;
      $display("timeout");
      $display("status: fail");
      $finish;
   end

   function automatic logic [63:0] abs64(input logic signed [63:0] x);
      return x[63] ? 64'd0 - x : x;
   endfunction

   function automatic longint rnd_half(input longint x);
      logic [63:0] r;
      r = (abs64(x) + 64'd536870912) >> 30;
      return x < 0 ? -longint'(r) : longint'(r);
   endfunction

   function automatic logic [63:0] int_sqrt(input logic [63:0] s);
      logic [63:0] res;
      logic [63:0] b;
      res = 0;
      b = 64'd1 << 62;
      while (b > s) b = b >> 2;
      while (b != 0) begin
         if (s >= res + b) begin
            s = s - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic bit unit_vec(input longint v[3], output longint o[3]);
      logic [63:0] m[3];
      logic [63:0] top;
      logic [63:0] len;
      logic [63:0] q;
      m[0] = abs64(v[0]);
      m[1] = abs64(v[1]);
      m[2] = abs64(v[2]);
      top = m[0];
      if (m[1] > top) top = m[1];
      if (m[2] > top) top = m[2];
      if (top == 0) return 1'b0;
      while (top < (64'd1 << 30)) begin
         top = top << 1;
         for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
      end
      while (top >= (64'd1 << 31)) begin
         top = top >> 1;
         for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
      end
      len = int_sqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
      for (int i = 0; i < 3; i++) begin
         q = ((m[i] << 30) + (len >> 1)) / len;
         if (q > 64'd1073741824) q = 64'd1073741824;
         o[i] = v[i] < 0 ? -longint'(q) : longint'(q);
      end
      return 1'b1;
   endfunction

   function automatic longint clip_unit(input longint x);
      if (x > 64'sd1073741824) return 64'sd1073741824;
      if (x < -64'sd1073741824) return -64'sd1073741824;
      return x;
   endfunction

   task automatic predict_view_rows(input lav_req_type rq);
      longint eye[3], tg[3], up[3], dv[3], rv[3];
      longint rw[3][3];
      longint d[3], r[3], u[3];
      longint dot, off;
      bit ok;
      lav_rsp_type e;
      eye = '{rq.eye_x, rq.eye_y, rq.eye_z};
      tg = '{rq.target_x, rq.target_y, rq.target_z};
      up = '{rq.up_x, rq.up_y, rq.up_z};
      for (int i = 0; i < 3; i++) dv[i] = eye[i] - tg[i];
      ok = unit_vec(dv, d);
      if (ok) begin
         rv[0] = up[1] * d[2] - up[2] * d[1];
         rv[1] = up[2] * d[0] - up[0] * d[2];
         rv[2] = up[0] * d[1] - up[1] * d[0];
         ok = unit_vec(rv, r);
      end
      if (ok) begin
         u[0] = clip_unit(rnd_half(d[1] * r[2] - d[2] * r[1]));
         u[1] = clip_unit(rnd_half(d[2] * r[0] - d[0] * r[2]));
         u[2] = clip_unit(rnd_half(d[0] * r[1] - d[1] * r[0]));
         rw[0] = r;
         rw[1] = u;
         rw[2] = d;
      end else begin
         n_degen++;
      end
      for (int k = 0; k < 3; k++) begin
         e = '0;
         e.row_index = k == 0 ? ROW_RIGHT : (k == 1 ? ROW_UP : ROW_BACK);
         e.last_row = k == 2;
         if (ok) begin
            dot = rw[k][0] * eye[0] + rw[k][1] * eye[1] + rw[k][2] * eye[2];
            off = -rnd_half(dot);
            if (off > 64'sd2147483647) off = 64'sd2147483647;
            if (off < -64'sd2147483648) off = -64'sd2147483648;
            e.coef_x = rw[k][0][31:0];
            e.coef_y = rw[k][1][31:0];
            e.coef_z = rw[k][2][31:0];
            e.offset = off[31:0];
         end else begin
            e.degenerate = 1'b1;
         end
         rows_due.push_back(e);
      end
   endtask

   task automatic send_request(input lav_req_type rq, input bit gaps);
      int gap;
      gap = gaps ? $urandom_range(0, 12) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data <= rq;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_view_rows(rq);
      n_req++;
      @(negedge clock);
   endtask

   // response side: random back-pressure, long hold when requested
   initial begin
      int wait_n;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (400) @(negedge clock);
            hold_rsp = 1'b0;
         end
         wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
         if (sim_done || $urandom_range(0, 1)) wait_n = 0;
         if (wait_n > 0) begin
            rsp_ready <= 1'b0;
            repeat (wait_n) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      lav_rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         n_rows++;
         if (rows_due.size() == 0) begin
            $error("response with no request outstanding");
            n_fail++;
         end else begin
            e = rows_due.pop_front();
            if (rsp_data.row_index !== e.row_index) begin
               $error("row_index exp %0d got %0d", e.row_index, rsp_data.row_index);
               n_fail++;
            end
            if (rsp_data.last_row !== e.last_row) begin
               $error("last_row exp %0d got %0d", e.last_row, rsp_data.last_row);
               n_fail++;
            end
            if (rsp_data.coef_x !== e.coef_x) begin
               $error("coef_x exp %0d got %0d", e.coef_x, rsp_data.coef_x);
               n_fail++;
            end
            if (rsp_data.coef_y !== e.coef_y) begin
               $error("coef_y exp %0d got %0d", e.coef_y, rsp_data.coef_y);
               n_fail++;
            end
            if (rsp_data.coef_z !== e.coef_z) begin
               $error("coef_z exp %0d got %0d", e.coef_z, rsp_data.coef_z);
               n_fail++;
            end
            if (rsp_data.offset !== e.offset) begin
               $error("offset exp %0d got %0d", e.offset, rsp_data.offset);
               n_fail++;
            end
            if (rsp_data.degenerate !== e.degenerate) begin
               $error("degenerate exp %0d got %0d", e.degenerate, rsp_data.degenerate);
               n_fail++;
            end
         end
      end
   end

   function automatic lav_req_type make_req(input longint ex, ey, ez, tx, ty, tz,
                                            ux, uy, uz);
      lav_req_type rq;
      rq.eye_x = 32'(ex); rq.eye_y = 32'(ey); rq.eye_z = 32'(ez);
      rq.target_x = 32'(tx); rq.target_y = 32'(ty); rq.target_z = 32'(tz);
      rq.up_x = 32'(ux); rq.up_y = 32'(uy); rq.up_z = 32'(uz);
      return rq;
   endfunction

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return 32'h8000_0000 + $urandom_range(0, 3);
         2: return 32'h7FFF_FFFF - $urandom_range(0, 3);
         3: return $urandom_range(0, 8) - 4;
         default: return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
      endcase
   endfunction

   task automatic test_directed();
      longint one;
      longint mx, mn;
      one = 64'sd65536;
      mx = 64'sd2147483647;
      mn = -64'sd2147483648;
      send_request(make_req(0, 0, 5 * one, 0, 0, 0, 0, one, 0), 1);
      send_request(make_req(one, 2 * one, 3 * one, one, 2 * one, 3 * one, 0, one, 0), 1);
      send_request(make_req(0, 5 * one, 0, 0, 0, 0, 0, one, 0), 1);
      send_request(make_req(0, 5 * one, 0, 0, 0, 0, 0, -3 * one, 0), 1);
      send_request(make_req(0, 0, 0, 0, 0, 0, 0, 0, 0), 1);
      send_request(make_req(one, 0, one, 0, 0, 0, 0, 0, 0), 1);
      send_request(make_req(mx, mx, mx, mn, mn, mn, 0, one, 0), 1);
      send_request(make_req(mn, mn, mn, mx, mx, mx, mn, mx, mn), 1);
      send_request(make_req(mx, mn, mx, mn, mx, mn, mx, mx, mx), 1);
      send_request(make_req(mn, mn, mn, mn, mn, mn + 1, mx, 0, 0), 1);
      send_request(make_req(mx, 0, 0, mx - 1, 0, 0, 0, 1, 0), 1);
      send_request(make_req(1, 1, 1, 0, 0, 0, 1, -1, 0), 1);
      send_request(make_req(mx, mx, 0, 0, 0, 0, -1, -1, 0), 1);
      send_request(make_req(-32'sd1, -32'sd1, -32'sd1, 0, 0, 0, mn, mn, mx), 1);
      send_request(make_req(3 * one, one, -4 * one, 0, one, 0, one, 0, one), 1);
   endtask

   task automatic test_random(input int count);
      lav_req_type rq;
      int pick;
      for (int i = 0; i < count; i++) begin
         rq.eye_x = rand_coord();
         rq.eye_y = rand_coord();
         rq.eye_z = rand_coord();
         rq.target_x = rand_coord();
         rq.target_y = rand_coord();
         rq.target_z = rand_coord();
         rq.up_x = rand_coord();
         rq.up_y = rand_coord();
         rq.up_z = rand_coord();
         pick = $urandom_range(0, 19);
         if (pick == 0) begin
            rq.target_x = rq.eye_x; rq.target_y = rq.eye_y; rq.target_z = rq.eye_z;
         end else if (pick == 1) begin
            rq.up_x = rq.eye_x - rq.target_x;
            rq.up_y = rq.eye_y - rq.target_y;
            rq.up_z = rq.eye_z - rq.target_z;
         end
         send_request(rq, $urandom_range(0, 3) != 0);
      end
   endtask

   task automatic test_backpressure();
      hold_rsp = 1'b1;
      test_random(40);
   endtask

   initial begin
      int settle;
      n_fail = 0; n_req = 0; n_rows = 0; n_degen = 0;
      hold_rsp = 1'b0; sim_done = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(150);
      test_backpressure();
      test_random(65);
      req_valid <= 1'b0;
      sim_done = 1'b1;
      settle = 0;
      while (rows_due.size() != 0 && settle < 20000) begin
         @(posedge clock);
         settle++;
      end
      repeat (200) @(posedge clock);
      $display("sent %0d requests, checked %0d rows, %0d degenerate requests",
               n_req, n_rows, n_degen);
      if (n_fail == 0 && rows_due.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire
